/* rtl/heightmap_bilinear_sampler_unit_assert.svh */
// assertion macros shared by the sampler modules
`ifndef HEIGHTMAP_BILINEAR_SAMPLER_UNIT_ASSERT_SVH
`define HEIGHTMAP_BILINEAR_SAMPLER_UNIT_ASSERT_SVH

// same-cycle implication, sampled on clk, off during rst
`define HBS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off during rst
`define HBS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/hbs_pkg.sv */
// shared types and constants of the heightmap sampler
`timescale 1ns / 1ps

package hbs_pkg;

  localparam int GRID_CELLS_DEF     = 64;
  localparam int CELL_SIZE_LOG2_DEF = 4;

  localparam int HEIGHT_W = 16;
  localparam int INDEX_W  = 13;
  localparam int WORLD_W  = 24;
  localparam int FRAC_W   = 8;

  localparam logic REQ_STORE  = 1'b0;
  localparam logic REQ_SAMPLE = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CELL,
    ST_BASE,
    ST_RD0,
    ST_RD1,
    ST_RD2,
    ST_RD3,
    ST_MUL_LO,
    ST_MUL_HI,
    ST_SUM_HI,
    ST_MUL_Z,
    ST_FIN
  } state_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_CELL,
    OP_BASE,
    OP_RD0,
    OP_RD1,
    OP_RD2,
    OP_RD3,
    OP_MUL_LO,
    OP_MUL_HI,
    OP_SUM_HI,
    OP_MUL_Z,
    OP_FIN
  } dp_op_t;

  typedef struct packed {
    logic   store;
    logic   load_query;
    dp_op_t op;
  } cmd_t;

  typedef struct packed {
    logic idx_ok;
    logic out_free;
  } status_t;

endpackage

/* rtl/hbs_ram.sv */
// generic single-port ram with registered read
`timescale 1ns / 1ps

module hbs_ram #(
  parameter int Width = 16,
  parameter int Depth = 4225
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] addr,
  input  logic [Width-1:0]         wdata,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

/* rtl/hbs_ctrl.sv */
// sequencer of the heightmap sampler
`timescale 1ns / 1ps
`include "heightmap_bilinear_sampler_unit_assert.svh"

module hbs_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic             req_type,
  input  hbs_pkg::status_t status,
  output hbs_pkg::cmd_t    cmd
);

  hbs_pkg::state_t state;
  hbs_pkg::state_t state_next;
  logic            accept;

  assign accept = in_valid && (state == hbs_pkg::ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= hbs_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      hbs_pkg::ST_IDLE: begin
        if (accept && (req_type == hbs_pkg::REQ_SAMPLE)) begin
          state_next = hbs_pkg::ST_CELL;
        end
      end
      hbs_pkg::ST_CELL:   state_next = hbs_pkg::ST_BASE;
      hbs_pkg::ST_BASE:   state_next = hbs_pkg::ST_RD0;
      hbs_pkg::ST_RD0:    state_next = hbs_pkg::ST_RD1;
      hbs_pkg::ST_RD1:    state_next = hbs_pkg::ST_RD2;
      hbs_pkg::ST_RD2:    state_next = hbs_pkg::ST_RD3;
      hbs_pkg::ST_RD3:    state_next = hbs_pkg::ST_MUL_LO;
      hbs_pkg::ST_MUL_LO: state_next = hbs_pkg::ST_MUL_HI;
      hbs_pkg::ST_MUL_HI: state_next = hbs_pkg::ST_SUM_HI;
      hbs_pkg::ST_SUM_HI: state_next = hbs_pkg::ST_MUL_Z;
      hbs_pkg::ST_MUL_Z:  state_next = hbs_pkg::ST_FIN;
      hbs_pkg::ST_FIN: begin
        if (status.out_free) begin
          state_next = hbs_pkg::ST_IDLE;
        end
      end
      default: state_next = hbs_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall       = (state != hbs_pkg::ST_IDLE);
    cmd.store      = accept && (req_type == hbs_pkg::REQ_STORE) && status.idx_ok;
    cmd.load_query = accept && (req_type == hbs_pkg::REQ_SAMPLE);
    cmd.op         = hbs_pkg::OP_NONE;
    unique case (state)
      hbs_pkg::ST_IDLE:   cmd.op = hbs_pkg::OP_NONE;
      hbs_pkg::ST_CELL:   cmd.op = hbs_pkg::OP_CELL;
      hbs_pkg::ST_BASE:   cmd.op = hbs_pkg::OP_BASE;
      hbs_pkg::ST_RD0:    cmd.op = hbs_pkg::OP_RD0;
      hbs_pkg::ST_RD1:    cmd.op = hbs_pkg::OP_RD1;
      hbs_pkg::ST_RD2:    cmd.op = hbs_pkg::OP_RD2;
      hbs_pkg::ST_RD3:    cmd.op = hbs_pkg::OP_RD3;
      hbs_pkg::ST_MUL_LO: cmd.op = hbs_pkg::OP_MUL_LO;
      hbs_pkg::ST_MUL_HI: cmd.op = hbs_pkg::OP_MUL_HI;
      hbs_pkg::ST_SUM_HI: cmd.op = hbs_pkg::OP_SUM_HI;
      hbs_pkg::ST_MUL_Z:  cmd.op = hbs_pkg::OP_MUL_Z;
      hbs_pkg::ST_FIN: begin
        if (status.out_free) begin
          cmd.op = hbs_pkg::OP_FIN;
        end
      end
      default: cmd.op = hbs_pkg::OP_NONE;
    endcase
  end

  `HBS_ASSERT_NEXT(a_query_starts, in_valid && !in_stall && (req_type == hbs_pkg::REQ_SAMPLE), state == hbs_pkg::ST_CELL, "query transfer did not start the sequence")
  `HBS_ASSERT_NEXT(a_store_stays_idle, in_valid && !in_stall && (req_type == hbs_pkg::REQ_STORE), state == hbs_pkg::ST_IDLE, "store transfer left idle")
  `HBS_ASSERT_NEXT(a_fin_holds, (state == hbs_pkg::ST_FIN) && !status.out_free, state == hbs_pkg::ST_FIN, "result dropped while output slot busy")

endmodule

/* rtl/hbs_datapath.sv */
// coordinate mapping, corner fetch and lerp datapath of the sampler
`timescale 1ns / 1ps
`include "heightmap_bilinear_sampler_unit_assert.svh"

module hbs_datapath #(
  parameter int GridCells    = hbs_pkg::GRID_CELLS_DEF,
  parameter int CellSizeLog2 = hbs_pkg::CELL_SIZE_LOG2_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  hbs_pkg::cmd_t                       cmd,
  output hbs_pkg::status_t                    status,
  input  logic [hbs_pkg::INDEX_W-1:0]         vertex_index,
  input  logic signed [hbs_pkg::HEIGHT_W-1:0] vertex_height,
  input  logic signed [hbs_pkg::WORLD_W-1:0]  world_x,
  input  logic signed [hbs_pkg::WORLD_W-1:0]  world_z,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [hbs_pkg::HEIGHT_W-1:0] sampled_height
);

  localparam int Verts  = GridCells + 1;
  localparam int Depth  = Verts * Verts;
  localparam int AddrW  = $clog2(Depth);
  localparam int IxW    = $clog2(GridCells);
  localparam int FracW  = hbs_pkg::FRAC_W;
  localparam int CellW  = IxW + FracW;
  localparam int HW     = hbs_pkg::HEIGHT_W;
  localparam int SumRaw = IxW + CellSizeLog2 + 10;
  localparam int SumW   = (SumRaw > hbs_pkg::WORLD_W + 1) ? SumRaw : hbs_pkg::WORLD_W + 1;
  localparam int DiffW  = HW + 1;
  localparam int ProdW  = DiffW + FracW + 1;

  localparam logic [SumW-1:0]  Half = SumW'(GridCells) << (CellSizeLog2 + 7);
  localparam logic [SumW-1:0]  MaxQ = SumW'(GridCells - 1) << FracW;
  localparam logic [AddrW-1:0] RowStep = AddrW'(Verts);

  function automatic logic [CellW-1:0] clamp_cell(input logic signed [SumW-1:0] s);
    logic [SumW-1:0] sh;
    sh = s >>> CellSizeLog2;
    if (s[SumW-1]) begin
      clamp_cell = '0;
    end else if (sh > MaxQ) begin
      clamp_cell = MaxQ[CellW-1:0];
    end else begin
      clamp_cell = sh[CellW-1:0];
    end
  endfunction

  logic signed [hbs_pkg::WORLD_W-1:0] wx_q;
  logic signed [hbs_pkg::WORLD_W-1:0] wz_q;
  logic signed [SumW-1:0]             sum_x;
  logic signed [SumW-1:0]             sum_z;
  logic [CellW-1:0]                   cell_x;
  logic [CellW-1:0]                   cell_z;
  logic [AddrW-1:0]                   base;
  logic signed [HW-1:0]               p00;
  logic signed [HW-1:0]               p10;
  logic signed [HW-1:0]               p01;
  logic signed [HW-1:0]               p11;
  logic signed [HW-1:0]               lower;
  logic signed [HW-1:0]               upper;
  logic signed [ProdW-1:0]            prod;
  logic signed [ProdW-FracW-1:0]      prod_sh;
  logic signed [HW-1:0]               mul_a;
  logic signed [HW-1:0]               mul_b;
  logic [FracW-1:0]                   mul_f;
  logic signed [DiffW-1:0]            diff;
  logic signed [FracW:0]              frac_s;
  logic signed [HW-1:0]               add_a;
  logic signed [HW-1:0]               add_res;
  logic                               ram_we;
  logic [AddrW-1:0]                   ram_addr;
  logic [HW-1:0]                      ram_q;

  assign sum_x = SumW'(wx_q) + $signed(Half);
  assign sum_z = SumW'(wz_q) + $signed(Half);

  always_ff @(posedge clk) begin
    if (cmd.load_query) begin
      wx_q <= world_x;
      wz_q <= world_z;
    end
    if (cmd.op == hbs_pkg::OP_CELL) begin
      cell_x <= clamp_cell(sum_x);
      cell_z <= clamp_cell(sum_z);
    end
    if (cmd.op == hbs_pkg::OP_BASE) begin
      base <= AddrW'(cell_z[CellW-1:FracW]) * RowStep + AddrW'(cell_x[CellW-1:FracW]);
    end
  end

  // single port shared by stores and the four corner reads
  assign ram_we = cmd.store;

  always_comb begin
    case (cmd.op)
      hbs_pkg::OP_RD0: ram_addr = base;
      hbs_pkg::OP_RD1: ram_addr = base + AddrW'(1);
      hbs_pkg::OP_RD2: ram_addr = base + RowStep;
      hbs_pkg::OP_RD3: ram_addr = base + RowStep + AddrW'(1);
      default:         ram_addr = AddrW'(vertex_index);
    endcase
  end

  hbs_ram #(
    .Width (HW),
    .Depth (Depth)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (vertex_height),
    .rdata (ram_q)
  );

  always_ff @(posedge clk) begin
    case (cmd.op)
      hbs_pkg::OP_RD1:    p00 <= $signed(ram_q);
      hbs_pkg::OP_RD2:    p10 <= $signed(ram_q);
      hbs_pkg::OP_RD3:    p01 <= $signed(ram_q);
      hbs_pkg::OP_MUL_LO: p11 <= $signed(ram_q);
      default: ;
    endcase
  end

  // one shared multiplier and one adder
  always_comb begin
    case (cmd.op)
      hbs_pkg::OP_MUL_HI: begin
        mul_a = p01;
        mul_b = p11;
        mul_f = cell_x[FracW-1:0];
      end
      hbs_pkg::OP_MUL_Z: begin
        mul_a = lower;
        mul_b = upper;
        mul_f = cell_z[FracW-1:0];
      end
      default: begin
        mul_a = p00;
        mul_b = p10;
        mul_f = cell_x[FracW-1:0];
      end
    endcase
    case (cmd.op)
      hbs_pkg::OP_SUM_HI: add_a = p01;
      hbs_pkg::OP_FIN:    add_a = lower;
      default:            add_a = p00;
    endcase
  end

  assign diff    = DiffW'(mul_b) - DiffW'(mul_a);
  assign frac_s  = $signed({1'b0, mul_f});
  assign prod_sh = prod[ProdW-1:FracW];
  assign add_res = add_a + prod_sh[HW-1:0];

  always_ff @(posedge clk) begin
    case (cmd.op)
      hbs_pkg::OP_MUL_LO: prod <= ProdW'(diff) * ProdW'(frac_s);
      hbs_pkg::OP_MUL_HI: begin
        lower <= add_res;
        prod  <= ProdW'(diff) * ProdW'(frac_s);
      end
      hbs_pkg::OP_SUM_HI: upper <= add_res;
      hbs_pkg::OP_MUL_Z:  prod <= ProdW'(diff) * ProdW'(frac_s);
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.op == hbs_pkg::OP_FIN) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == hbs_pkg::OP_FIN) begin
      sampled_height <= add_res;
    end
  end

  assign status.idx_ok   = (32'(vertex_index) < Depth);
  assign status.out_free = !out_valid || !out_stall;

  `HBS_ASSERT_NOW(a_out_from_fin, $rose(out_valid), $past(cmd.op == hbs_pkg::OP_FIN), "output valid rose without a finish step")
  `HBS_ASSERT_NOW(a_fin_when_free, cmd.op == hbs_pkg::OP_FIN, status.out_free, "finish step overwrote a waiting result")
  `HBS_ASSERT_NOW(a_write_only_idle, ram_we, cmd.op == hbs_pkg::OP_NONE, "height write during a corner fetch")

endmodule

/* rtl/heightmap_bilinear_sampler_unit.sv */
// top level of the bilinear heightmap sampler
`timescale 1ns / 1ps

// Heightmap sampler: holds (GridCells+1)^2 vertex heights (signed Q8.8,
// row-major) in one single-port ram, 4225 entries at the default 64 cells.
// A store transfer (req_type 0) writes one height in the cycle it is taken
// and the block can take another transfer in the next cycle; stores at or
// past the end of the grid are dropped. A sample transfer (req_type 1)
// maps world_x/world_z (signed Q16.8) into clamped cell coordinates with
// 8 fraction bits, fetches the four corners and blends them, first along
// X, then along Z. A sample keeps the block busy through the coordinate
// and address math, the four corner reads through the single ram port
// and the three lerps on one shared multiplier, after which the result
// shows on out_valid. The result sits in an output register, so the block
// takes the next transfer while a result still waits on out_stall; only a
// second finished result stalls behind it. Entries are undefined until
// written, and a sample touching an unwritten vertex returns garbage.

module heightmap_bilinear_sampler_unit #(
  parameter int GridCells    = hbs_pkg::GRID_CELLS_DEF,
  parameter int CellSizeLog2 = hbs_pkg::CELL_SIZE_LOG2_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  // request channel
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                req_type,
  input  logic [hbs_pkg::INDEX_W-1:0]         vertex_index,
  input  logic signed [hbs_pkg::HEIGHT_W-1:0] vertex_height,
  input  logic signed [hbs_pkg::WORLD_W-1:0]  world_x,
  input  logic signed [hbs_pkg::WORLD_W-1:0]  world_z,
  // result channel
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [hbs_pkg::HEIGHT_W-1:0] sampled_height
);

  // controller to datapath commands and status back
  hbs_pkg::cmd_t    cmd;
  hbs_pkg::status_t status;

  // sequencer: one sample at a time, stores go straight through
  hbs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .req_type (req_type),
    .status   (status),
    .cmd      (cmd)
  );

  // coordinate mapping, height ram, shared lerp unit and output register
  hbs_datapath #(
    .GridCells    (GridCells),
    .CellSizeLog2 (CellSizeLog2)
  ) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .status         (status),
    .vertex_index   (vertex_index),
    .vertex_height  (vertex_height),
    .world_x        (world_x),
    .world_z        (world_z),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .sampled_height (sampled_height)
  );

endmodule
